[rtl/twes_pkg.sv]
// shared types and constants for the timing wheel event scheduler
`default_nettype none
package twes_pkg;

  localparam int DELAY_W   = 26;
  localparam int LIMIT_W   = 25;
  localparam int FIELD_W   = 16;
  localparam int PAY_W     = 3 * FIELD_W;
  localparam int FRAME_W   = 32;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd20000000;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_POOL_FULL = 3'd2,
    ST_NO_TARGET = 3'd3,
    ST_FIRED     = 3'd4,
    ST_IDLE_TICK = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_CHK,
    S_A_ALLOC,
    S_O_RD,
    S_O_CMP,
    S_O_LINK,
    S_O_PREV,
    S_A_RESP,
    S_T_START,
    S_T_LIST,
    S_T_HEAD,
    S_T_RD,
    S_T_EMIT,
    S_T_NEXTP,
    S_T_OVF,
    S_T_OCHK,
    S_T_END
  } state_t;

endpackage
`default_nettype wire

[rtl/timing_wheel_event_scheduler_unit.sv]
// timing wheel event scheduler with sorted overflow list, top level
//
// channel | direction | handshake           | contents
// --------+-----------+---------------------+-------------------------------------------
// in      | input     | in_valid / in_stall | action, delay, code, target, tag, priority
// out     | output    | out_valid/out_stall | status, fired fields, pending, last flag
// cfg     | input     | cfg_valid/cfg_ready | drop_limit_ticks write data
//
// one item at a time; an add into a slot reads the free entry and its list, then allocates
// and links the entry, then responds; a rejected add responds straight after the check; an
// overflow add walks the sorted overflow list (one entry memory read per step), then links
// the new entry in; a tick fires the events of each non-empty priority list of the old slot
// in turn, then pops the due overflow heads; the single entry read port sets this pace
// synchronous reset clears the control state (old slot aside) at once; no clearing pass is needed
// a stalled result holds the sequencer; the input is taken again only when idle
`default_nettype none
module timing_wheel_event_scheduler_unit #(
  parameter int SLOTS      = 64,
  parameter int POOL_DEPTH = 64,
  parameter int PRIORITIES = 2
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  logic                           in_valid,
  output logic                                 in_stall,
  input  wire  logic                           action,
  input  wire  logic [twes_pkg::DELAY_W-1:0]   delay_ticks,
  input  wire  logic [twes_pkg::FIELD_W-1:0]   event_code,
  input  wire  logic [twes_pkg::FIELD_W-1:0]   target_handle,
  input  wire  logic [twes_pkg::FIELD_W-1:0]   payload_tag,
  input  wire  logic                           priority_level,
  output logic                                 out_valid,
  input  wire  logic                           out_stall,
  output logic [twes_pkg::STATUS_W-1:0]        status,
  output logic [twes_pkg::FIELD_W-1:0]         fired_code,
  output logic [twes_pkg::FIELD_W-1:0]         fired_target,
  output logic [twes_pkg::FIELD_W-1:0]         fired_payload,
  output logic [twes_pkg::COUNT_W-1:0]         pending_count,
  output logic                                 last_of_run,
  input  wire  logic                           cfg_valid,
  output logic                                 cfg_ready,
  input  wire  logic [twes_pkg::LIMIT_W-1:0]   cfg_data
);
  import twes_pkg::*;

  localparam int PW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LINKW = PW + 1;          // msb set means none (or fresh, on the free list)
  localparam int SW    = $clog2(SLOTS);
  localparam int LISTS = SLOTS * PRIORITIES;
  localparam int LIW   = $clog2(LISTS);
  localparam int PRW   = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
  localparam logic [LINKW-1:0] NONE = {1'b1, {PW{1'b0}}};

  // entry and list memories
  logic [PAY_W-1:0]   ent_pay  [POOL_DEPTH];
  logic [FRAME_W-1:0] ent_due  [POOL_DEPTH];
  logic [LINKW-1:0]   ent_link [POOL_DEPTH];
  logic [PW-1:0]      list_head[LISTS];
  logic [PW-1:0]      list_tail[LISTS];
  logic [LISTS-1:0]   list_vld;

  logic [PAY_W-1:0]   pay_rd;
  logic [FRAME_W-1:0] due_rd;
  logic [LINKW-1:0]   link_rd;
  logic [PW-1:0]      head_rd, tail_rd;

  state_t state, state_next;

  // control registers
  logic [LIMIT_W-1:0] limit;
  logic [LINKW-1:0]   free_head;
  logic [PW:0]        fresh_cnt;
  logic [LINKW-1:0]   ovf_head;
  logic [SW-1:0]      cur_slot, old_slot;
  logic [FRAME_W-1:0] frame;
  logic [COUNT_W-1:0] held;

  // latched input item
  logic [DELAY_W-1:0] r_delay;
  logic [FIELD_W-1:0] r_code, r_tgt, r_tag;
  logic               r_pri;

  // add bookkeeping
  logic [PW-1:0]      a_ent;
  logic               a_fresh, a_ovf;
  logic [LIW-1:0]     a_li;
  logic [FRAME_W-1:0] a_due, a_key;
  status_t            res_status;
  logic [LINKW-1:0]   ocur, oprev;

  // tick bookkeeping
  logic [PRW-1:0]     p_idx;
  logic [PW-1:0]      wcur, wtail;
  logic               pend_valid;
  logic [PAY_W-1:0]   pend_pay;
  logic [COUNT_W-1:0] pend_cnt;

  // add classification
  logic               d_gt1, too_far, ovf_c;
  logic [DELAY_W-1:0] off;
  logic [SW:0]        slot_sum;
  logic [SW-1:0]      slot_c;
  logic [PRW-1:0]     pri_c;
  logic [LIW-1:0]     li_c, t_li;
  logic [FRAME_W-1:0] due_c;
  logic [SW:0]        cur_inc;
  logic [FRAME_W-1:0] o_diff;
  logic               o_adv, t_fire;

  always_comb begin
    d_gt1    = $signed(r_delay) > $signed(26'sd1);
    too_far  = d_gt1 && ($signed(r_delay) > $signed({1'b0, limit}));
    off      = r_delay - DELAY_W'(1);
    ovf_c    = d_gt1 && (off >= DELAY_W'(SLOTS - 2));
    slot_sum = {1'b0, cur_slot} + {1'b0, off[SW-1:0]};
    if (!d_gt1) begin
      slot_c = cur_slot;
    end else if (slot_sum >= (SW+1)'(SLOTS)) begin
      slot_c = SW'(slot_sum - (SW+1)'(SLOTS));
    end else begin
      slot_c = slot_sum[SW-1:0];
    end
    pri_c   = (int'(r_pri) >= PRIORITIES) ? PRW'(PRIORITIES - 1) : PRW'(r_pri);
    li_c    = LIW'(int'(slot_c) * PRIORITIES + int'(pri_c));
    due_c   = d_gt1 ? frame + {{(FRAME_W-DELAY_W){1'b0}}, r_delay} : frame;
    t_li    = LIW'(int'(old_slot) * PRIORITIES + int'(p_idx));
    cur_inc = {1'b0, cur_slot} + (SW+1)'(1);
    // distance of the entry just read from the current frame
    o_diff  = due_rd - frame;
    o_adv   = o_diff <= a_key;
    t_fire  = o_diff[FRAME_W-1];
  end

  // next state
  logic out_free, can_push;
  assign out_free = !out_valid || !out_stall;
  assign can_push = !pend_valid || out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = action ? S_T_START : S_A_CHK;
      S_A_CHK:   state_next = ((r_tgt == '0) || too_far || (held == COUNT_W'(POOL_DEPTH))) ?
                              S_A_RESP : S_A_ALLOC;
      S_A_ALLOC: state_next = a_ovf ? S_O_RD : S_A_RESP;
      S_O_RD:    state_next = ocur[PW] ? S_O_LINK : S_O_CMP;
      S_O_CMP:   state_next = o_adv ? S_O_RD : S_O_LINK;
      S_O_LINK:  state_next = S_O_PREV;
      S_O_PREV:  state_next = S_A_RESP;
      S_A_RESP:  if (out_free) state_next = S_IDLE;
      S_T_START: state_next = S_T_LIST;
      S_T_LIST:  state_next = list_vld[t_li] ? S_T_HEAD : S_T_NEXTP;
      S_T_HEAD:  state_next = S_T_RD;
      S_T_RD:    state_next = S_T_EMIT;
      S_T_EMIT:  if (can_push) state_next = (wcur == wtail) ? S_T_NEXTP : S_T_RD;
      S_T_NEXTP: state_next = (int'(p_idx) == PRIORITIES - 1) ? S_T_OVF : S_T_LIST;
      S_T_OVF:   state_next = ovf_head[PW] ? S_T_END : S_T_OCHK;
      S_T_OCHK:  begin
        if (!t_fire) state_next = S_T_END;
        else if (can_push) state_next = S_T_OVF;
      end
      S_T_END:   if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory strobes and result loads
  logic               ent_re, pd_we, link_we, list_re, lh_we, lt_we, push, out_load;
  logic [PW-1:0]      ent_ra, link_wa;
  logic [LINKW-1:0]   link_wd;
  logic [LIW-1:0]     list_ra;
  status_t            ld_status;
  logic [PAY_W-1:0]   ld_pay;
  logic [COUNT_W-1:0] ld_cnt;
  logic               ld_last;

  always_comb begin
    in_stall  = 1'b1;
    ent_re    = 1'b0;
    ent_ra    = '0;
    pd_we     = 1'b0;
    link_we   = 1'b0;
    link_wa   = '0;
    link_wd   = NONE;
    list_re   = 1'b0;
    list_ra   = '0;
    lh_we     = 1'b0;
    lt_we     = 1'b0;
    push      = 1'b0;
    out_load  = 1'b0;
    ld_status = ST_FIRED;
    ld_pay    = pend_pay;
    ld_cnt    = pend_cnt;
    ld_last   = 1'b0;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_A_CHK: begin
        ent_re  = 1'b1;
        ent_ra  = free_head[PW-1:0];
        list_re = 1'b1;
        list_ra = li_c;
      end
      S_A_ALLOC: begin
        pd_we = 1'b1;
        if (!a_ovf) begin
          lt_we = 1'b1;
          if (list_vld[a_li]) begin
            link_we = 1'b1;
            link_wa = tail_rd;
            link_wd = {1'b0, a_ent};
          end else begin
            lh_we = 1'b1;
          end
        end
      end
      S_O_RD: begin
        ent_re = !ocur[PW];
        ent_ra = ocur[PW-1:0];
      end
      S_O_LINK: begin
        link_we = 1'b1;
        link_wa = a_ent;
        link_wd = ocur;
      end
      S_O_PREV: begin
        link_we = !oprev[PW];
        link_wa = oprev[PW-1:0];
        link_wd = {1'b0, a_ent};
      end
      S_A_RESP: begin
        out_load  = out_free;
        ld_status = res_status;
        ld_pay    = '0;
        ld_cnt    = held;
        ld_last   = 1'b1;
      end
      S_T_LIST: begin
        list_re = list_vld[t_li];
        list_ra = t_li;
      end
      S_T_RD: begin
        ent_re = 1'b1;
        ent_ra = wcur;
      end
      S_T_EMIT: begin
        push     = can_push;
        out_load = can_push && pend_valid;
        link_we  = can_push;
        link_wa  = wcur;
        link_wd  = free_head;
      end
      S_T_OVF: begin
        ent_re = !ovf_head[PW];
        ent_ra = ovf_head[PW-1:0];
      end
      S_T_OCHK: begin
        push     = t_fire && can_push;
        out_load = t_fire && can_push && pend_valid;
        link_we  = t_fire && can_push;
        link_wa  = ovf_head[PW-1:0];
        link_wd  = free_head;
      end
      S_T_END: begin
        out_load  = out_free;
        ld_last   = 1'b1;
        if (!pend_valid) begin
          ld_status = ST_IDLE_TICK;
          ld_pay    = '0;
          ld_cnt    = held;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  assign cfg_ready = 1'b1;

  // entry memory, one read address shared by all three fields
  always_ff @(posedge clk) begin
    if (pd_we) begin
      ent_pay[a_ent] <= {r_code, r_tgt, r_tag};
      ent_due[a_ent] <= a_due;
    end
    if (link_we) ent_link[link_wa] <= link_wd;
    if (ent_re) begin
      pay_rd  <= ent_pay[ent_ra];
      due_rd  <= ent_due[ent_ra];
      link_rd <= ent_link[ent_ra];
    end
  end

  // per-list head and tail memories
  always_ff @(posedge clk) begin
    if (lh_we) list_head[a_li] <= a_ent;
    if (lt_we) list_tail[a_li] <= a_ent;
    if (list_re) begin
      head_rd <= list_head[list_ra];
      tail_rd <= list_tail[list_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= LIMIT_RESET;
      free_head  <= NONE;
      fresh_cnt  <= '0;
      ovf_head   <= NONE;
      cur_slot   <= '0;
      frame      <= '0;
      held       <= '0;
      list_vld   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) limit <= cfg_data;

      // result register: a load wins over the outgoing transfer
      if (out_load) begin
        out_valid     <= 1'b1;
        status        <= ld_status;
        fired_code    <= ld_pay[PAY_W-1 -: FIELD_W];
        fired_target  <= ld_pay[FIELD_W +: FIELD_W];
        fired_payload <= ld_pay[FIELD_W-1:0];
        pending_count <= ld_cnt;
        last_of_run   <= ld_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // fired event goes to the staging slot until the next one shows whether it is last
      if (push) begin
        pend_valid <= 1'b1;
        pend_pay   <= pay_rd;
        pend_cnt   <= held - COUNT_W'(1);
        held       <= held - COUNT_W'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_delay  <= delay_ticks;
            r_code   <= event_code;
            r_tgt    <= target_handle;
            r_tag    <= payload_tag;
            r_pri    <= priority_level;
          end
        end
        S_A_CHK: begin
          a_ent   <= free_head[PW] ? fresh_cnt[PW-1:0] : free_head[PW-1:0];
          a_fresh <= free_head[PW];
          a_li    <= li_c;
          a_ovf   <= ovf_c;
          a_due   <= due_c;
          a_key   <= {{(FRAME_W-DELAY_W){1'b0}}, r_delay};
          if (r_tgt == '0) res_status <= ST_NO_TARGET;
          else if (too_far) res_status <= ST_DROPPED;
          else if (held == COUNT_W'(POOL_DEPTH)) res_status <= ST_POOL_FULL;
          else res_status <= ST_ADDED;
        end
        S_A_ALLOC: begin
          // entries never handed out are taken in order once the free stack runs dry
          if (a_fresh) fresh_cnt <= fresh_cnt + (PW+1)'(1);
          else free_head <= link_rd;
          held  <= held + COUNT_W'(1);
          if (!a_ovf) list_vld[a_li] <= 1'b1;
          ocur  <= ovf_head;
          oprev <= NONE;
        end
        S_O_CMP: begin
          if (o_adv) begin
            oprev <= ocur;
            ocur  <= link_rd;
          end
        end
        S_O_PREV: begin
          if (oprev[PW]) ovf_head <= {1'b0, a_ent};
        end
        S_T_START: begin
          frame    <= frame + FRAME_W'(1);
          cur_slot <= (cur_inc == (SW+1)'(SLOTS)) ? '0 : cur_inc[SW-1:0];
          old_slot <= cur_slot;
          p_idx    <= '0;
        end
        S_T_HEAD: begin
          wcur           <= head_rd;
          wtail          <= tail_rd;
          list_vld[t_li] <= 1'b0;
        end
        S_T_EMIT: begin
          if (can_push) begin
            free_head <= {1'b0, wcur};
            wcur      <= link_rd[PW-1:0];
          end
        end
        S_T_NEXTP: begin
          if (int'(p_idx) != PRIORITIES - 1) p_idx <= p_idx + PRW'(1);
        end
        S_T_OCHK: begin
          if (t_fire && can_push) begin
            ovf_head  <= link_rd;
            free_head <= ovf_head;
          end
        end
        S_T_END: begin
          if (out_free) pend_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/twes_checker.sv]
// port-level checks for the timing wheel event scheduler
`default_nettype none
module twes_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic [15:0] fired_code,
  input wire logic [15:0] fired_target,
  input wire logic [15:0] fired_payload,
  input wire logic [6:0]  pending_count,
  input wire logic        last_of_run
);
  import twes_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(pending_count))
    else $error("stalled result changed");

  // only fired events may be followed by more results of the same item
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_FIRED) |-> last_of_run)
    else $error("non-fired result not last");

  // fired fields are zero unless an event fired
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_FIRED) |->
      (fired_code == '0) && (fired_target == '0) && (fired_payload == '0))
    else $error("fired fields set without a fired event");

  // pool never holds more than its depth, and status is a defined code
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending_count <= 7'd64) && (status <= 3'd5))
    else $error("pending count or status out of range");

endmodule

bind timing_wheel_event_scheduler_unit twes_checker u_twes_checker (.*);
`default_nettype wire

[sim/tb_timing_wheel_event_scheduler_unit.sv]
// testbench for the timing wheel event scheduler: directed and random adds and ticks vs a predictor
`timescale 1ns / 1ps
module tb_timing_wheel_event_scheduler_unit;
  import twes_pkg::*;

  localparam int SLOTS      = 64;
  localparam int POOL_DEPTH = 64;
  localparam int PRIORITIES = 2;
  localparam int LINK_NONE  = 127;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  // one expected result
  typedef struct {
    status_t            st;
    logic [FIELD_W-1:0] code;
    logic [FIELD_W-1:0] tgt;
    logic [FIELD_W-1:0] tag;
    logic [COUNT_W-1:0] pending;
    logic               last;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [DELAY_W-1:0] delay_ticks = '0;
  logic [FIELD_W-1:0] event_code = '0;
  logic [FIELD_W-1:0] target_handle = '0;
  logic [FIELD_W-1:0] payload_tag = '0;
  logic priority_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0] fired_code, fired_target, fired_payload;
  logic [COUNT_W-1:0] pending_count;
  logic last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  timing_wheel_event_scheduler_unit #(
    .SLOTS(SLOTS), .POOL_DEPTH(POOL_DEPTH), .PRIORITIES(PRIORITIES)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .delay_ticks(delay_ticks), .event_code(event_code),
    .target_handle(target_handle), .payload_tag(payload_tag),
    .priority_level(priority_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .fired_code(fired_code), .fired_target(fired_target),
    .fired_payload(fired_payload), .pending_count(pending_count),
    .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predicted scheduler state
  logic [PAY_W-1:0]   ent_pay [POOL_DEPTH];
  logic [FRAME_W-1:0] ent_due [POOL_DEPTH];
  int                 ent_link[POOL_DEPTH];
  int                 list_head[SLOTS*PRIORITIES];
  int                 list_tail[SLOTS*PRIORITIES];
  int                 ovf_head, free_head, wheel_slot, held;
  logic [FRAME_W-1:0] frame;
  logic [LIMIT_W-1:0] drop_limit;

  sched_result_t due_results[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  gaps_on = 1'b1;   // cleared for stretches of back-to-back transfers

  function automatic int draw_gap();
    return gaps_on ? $urandom_range(0, 12) : 0;
  endfunction

  task automatic sched_reset();
    for (int i = 0; i < POOL_DEPTH; i++)
      ent_link[i] = (i + 1 < POOL_DEPTH) ? i + 1 : LINK_NONE;
    for (int i = 0; i < SLOTS*PRIORITIES; i++) begin
      list_head[i] = LINK_NONE;
      list_tail[i] = 0;
    end
    ovf_head = LINK_NONE;
    free_head = 0;
    wheel_slot = 0;
    held = 0;
    frame = '0;
    drop_limit = LIMIT_RESET;
  endtask

  task automatic push_result(status_t st, logic [PAY_W-1:0] pl, logic last);
    sched_result_t r;
    r.st = st;
    r.code = pl[47:32];
    r.tgt = pl[31:16];
    r.tag = pl[15:0];
    r.pending = held[COUNT_W-1:0];
    r.last = last;
    due_results.push_back(r);
  endtask

  task automatic free_entry(int e);
    ent_link[e] = free_head;
    free_head = e;
    if (held > 0) held--;
  endtask

  // work out the results of one accepted add
  task automatic predict_add(logic [DELAY_W-1:0] dly, logic [FIELD_W-1:0] code,
                             logic [FIELD_W-1:0] tgt, logic [FIELD_W-1:0] tag, logic pri);
    int d, slot, e, prev, cur, li;
    bit to_ovf;
    logic [FRAME_W-1:0] due, key;
    d = {{(32-DELAY_W){dly[DELAY_W-1]}}, dly};
    slot = wheel_slot;
    due = frame;
    to_ovf = 1'b0;
    if (tgt == 0) begin
      push_result(ST_NO_TARGET, '0, 1'b1);
      return;
    end
    if (d > 1) begin
      if (d > int'(drop_limit)) begin
        push_result(ST_DROPPED, '0, 1'b1);
        return;
      end
      due = frame + d;
      if (d - 1 >= SLOTS - 2) to_ovf = 1'b1;
      else slot = (wheel_slot + d - 1) % SLOTS;
    end
    if (free_head >= POOL_DEPTH) begin
      push_result(ST_POOL_FULL, '0, 1'b1);
      return;
    end
    e = free_head;
    free_head = ent_link[e];
    ent_pay[e] = {code, tgt, tag};
    ent_due[e] = due;
    ent_link[e] = LINK_NONE;
    if (to_ovf) begin
      // sorted by distance from the current frame, stable on ties
      key = due - frame;
      prev = LINK_NONE;
      cur = ovf_head;
      while (cur < POOL_DEPTH && (ent_due[cur] - frame) <= key) begin
        prev = cur;
        cur = ent_link[cur];
      end
      ent_link[e] = cur;
      if (prev < POOL_DEPTH) ent_link[prev] = e;
      else ovf_head = e;
    end else begin
      li = slot * PRIORITIES + pri;
      if (list_head[li] < POOL_DEPTH) ent_link[list_tail[li]] = e;
      else list_head[li] = e;
      list_tail[li] = e;
    end
    held++;
    push_result(ST_ADDED, '0, 1'b1);
  endtask

  // work out the results of one accepted tick
  task automatic predict_tick();
    int old, n, cur, nxt, li;
    logic [PAY_W-1:0] pl;
    logic [FRAME_W-1:0] diff;
    old = wheel_slot;
    n = 0;
    frame = frame + 1;
    wheel_slot = (wheel_slot + 1) % SLOTS;
    for (int p = 0; p < PRIORITIES; p++) begin
      li = old * PRIORITIES + p;
      cur = list_head[li];
      while (cur < POOL_DEPTH) begin
        nxt = ent_link[cur];
        pl = ent_pay[cur];
        free_entry(cur);
        push_result(ST_FIRED, pl, 1'b0);
        n++;
        cur = nxt;
      end
      list_head[li] = LINK_NONE;
    end
    while (ovf_head < POOL_DEPTH) begin
      diff = ent_due[ovf_head] - frame;
      if (!diff[FRAME_W-1]) break;
      cur = ovf_head;
      pl = ent_pay[cur];
      ovf_head = ent_link[cur];
      free_entry(cur);
      push_result(ST_FIRED, pl, 1'b0);
      n++;
    end
    if (n == 0) push_result(ST_IDLE_TICK, '0, 1'b1);
    else due_results[$].last = 1'b1;
  endtask

  // one input transfer, with a random gap in front
  task automatic send_item(logic act, logic [DELAY_W-1:0] dly, logic [FIELD_W-1:0] code,
                           logic [FIELD_W-1:0] tgt, logic [FIELD_W-1:0] tag, logic pri);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    delay_ticks <= dly;
    event_code <= code;
    target_handle <= tgt;
    payload_tag <= tag;
    priority_level <= pri;
    do @(posedge clk); while (in_stall);
    if (act == ACT_ADD) predict_add(dly, code, tgt, tag, pri);
    else predict_tick();
  endtask

  task automatic add_event(int dly, logic [FIELD_W-1:0] tgt, logic pri);
    send_item(ACT_ADD, dly[DELAY_W-1:0], FIELD_W'($urandom), tgt, FIELD_W'($urandom), pri);
  endtask

  task automatic tick();
    send_item(ACT_TICK, DELAY_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
              FIELD_W'($urandom), 1'($urandom));
  endtask

  // wait for every result, then for any work still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // limit register write, only with the block idle
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    drop_limit = value;
  endtask

  // field extremes, negative and boundary delays, both priorities, no target
  task automatic test_directed_edges();
    add_event(5, 16'hffff, 1'b1);
    add_event(5, 16'h0001, 1'b0);
    add_event(1, 16'h1234, 1'b1);
    add_event(0, 16'h2222, 1'b0);
    add_event(-33554432, 16'h3333, 1'b0);       // most negative delay, current slot
    add_event(2, 16'h4444, 1'b1);
    add_event(62, 16'h5555, 1'b0);             // last slot in the wheel
    add_event(63, 16'h6666, 1'b0);             // first overflow delay
    add_event(63, 16'h7777, 1'b1);             // tie in overflow keeps order
    add_event(64, 16'h8888, 1'b0);
    add_event(33554431, 16'h9999, 1'b0);       // above the reset limit, dropped
    send_item(ACT_ADD, 26'd3, 16'hffff, 16'h0000, 16'hffff, 1'b1);  // no target
    send_item(ACT_ADD, 26'd3, 16'h0000, 16'hfffe, 16'h0000, 1'b0);
    for (int i = 0; i < 8; i++) tick();
  endtask

  // fill the pool, see pool full, then fire large runs
  task automatic test_pool_full();
    for (int i = 0; i < POOL_DEPTH + 3; i++)
      add_event($urandom_range(0, 3), FIELD_W'($urandom_range(1, 65535)), 1'($urandom));
    add_event(30000000, 16'h0101, 1'b0);       // drop beats pool full
    for (int i = 0; i < 6; i++) tick();
  endtask

  // a drop limit of one and the largest drop limit
  task automatic test_drop_limit();
    write_limit(25'd1);
    add_event(2, 16'h00aa, 1'b0);
    add_event(1, 16'h00ab, 1'b1);
    add_event(-1, 16'h00ac, 1'b0);
    tick();
    write_limit(LIMIT_MAX);
    add_event(33554431, 16'h00ad, 1'b0);
    add_event(100, 16'h00ae, 1'b1);
    tick();
  endtask

  // mostly well-formed adds and ticks, some noise
  task automatic test_random(int count);
    int r, dly;
    for (int i = 0; i < count; i++) begin
      gaps_on = (i % 50) < 35;
      r = $urandom_range(0, 99);
      if (r < 38) tick();
      else begin
        case ($urandom_range(0, 9))
          0:       dly = $urandom_range(0, 40) - 20;
          1:       dly = $urandom_range(62, 140);
          2:       dly = $signed($urandom) >>> 6;
          default: dly = $urandom_range(0, 64);
        endcase
        add_event(dly, (r < 42) ? 16'h0000 : FIELD_W'($urandom_range(1, 65535)),
                  1'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  // result checking and random receive stalls
  int stall_left = 0;
  always @(posedge clk) begin
    sched_result_t x;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: status %0d", status);
      end else begin
        x = due_results.pop_front();
        if (status !== x.st || fired_code !== x.code || fired_target !== x.tgt ||
            fired_payload !== x.tag || pending_count !== x.pending ||
            last_of_run !== x.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d %h %h %h pend %0d last %0d, ",
                      "got st %0d %h %h %h pend %0d last %0d"},
                     x.st, x.code, x.tgt, x.tag, x.pending, x.last, status, fired_code,
                     fired_target, fired_payload, pending_count, last_of_run);
        end
      end
      stall_left = draw_gap();
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    sched_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_pool_full();
    test_random(25);
    test_drop_limit();
    write_limit(25'd70);
    test_random(25);
    drain();
    if (mismatches == 0 && due_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
